FILE: design/free_list_handle_allocator_assert.svh
// assertion macros for the handle allocator
`ifndef FREE_LIST_HANDLE_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FHLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FHLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fhla_pkg.sv
`default_nettype none

package fhla_pkg;

    localparam int CMD_W    = 2;
    localparam int OBJ_W    = 32;
    localparam int NAME_W   = 16;
    localparam int STATUS_W = 2;

    localparam int SLOTS_DEFAULT       = 256;
    localparam int OBJECT_BITS_DEFAULT = 32;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

FILE: design/fhla_if.sv
`default_nettype none

interface fhla_in_if import fhla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [OBJ_W-1:0]    object_value;
    logic [NAME_W-1:0]   name_in;

    modport source (output valid, output cmd, output object_value, output name_in,
                    input ready);
    modport sink   (input valid, input cmd, input object_value, input name_in,
                    output ready);
endinterface

interface fhla_out_if import fhla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NAME_W-1:0]   name_out;
    logic                is_live;
    logic [OBJ_W-1:0]    object_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output name_out, output is_live, output object_out,
                    output status, input ready);
    modport sink   (input valid, input name_out, input is_live, input object_out,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: design/fhla_ram.sv
`default_nettype none

module fhla_ram import fhla_pkg::*; #(
    parameter int WIDTH = OBJECT_BITS_DEFAULT,
    parameter int DEPTH = SLOTS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/free_list_handle_allocator.sv
// Handle allocator over SLOTS table slots kept on an in-place LIFO free list.
// The table memories are read in the cycle a command word is accepted (S_IDLE);
// the entry is updated and the result registered in the S_EXEC state that
// follows, so a new word is taken only once the last has completed; a result
// held back by the sink stalls the block in S_EXEC. A fill count marks how far
// the table has ever been handed out, so slots past it read as free and linked
// in ascending order: no clearing pass after reset.
`default_nettype none

`include "free_list_handle_allocator_assert.svh"

module free_list_handle_allocator import fhla_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEFAULT,
    parameter int OBJECT_BITS = OBJECT_BITS_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    fhla_in_if.sink  req,
    fhla_out_if.source rsp
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = OBJECT_BITS + 1;

    localparam logic [IDX_W-1:0]  SLOTS_I = IDX_W'(SLOTS);
    localparam logic [NAME_W-1:0] SLOTS_N = NAME_W'(SLOTS);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       fill_reg, fill_next;
    logic [CMD_W-1:0]       cmd_reg;
    logic [OBJECT_BITS-1:0] obj_reg;
    logic [NAME_W-1:0]      name_reg;
    logic [ADDR_W-1:0]      nidx_reg;
    logic                   inrange_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [NAME_W-1:0]      out_name_reg, out_name_next;
    logic                   out_live_reg, out_live_next;
    logic [OBJ_W-1:0]       out_obj_reg, out_obj_next;
    status_t                out_status_reg, out_status_next;

    logic                   accept;
    logic                   complete;
    logic                   rsp_free;

    logic [NAME_W-1:0]      name_dec;
    logic [ADDR_W-1:0]      rd_addr;

    logic [IDX_W-1:0]       link_rd;
    logic [DATA_W-1:0]      data_rd;

    logic                   link_we;
    logic [ADDR_W-1:0]      link_waddr;
    logic [IDX_W-1:0]       link_wdata;
    logic                   data_we;
    logic [ADDR_W-1:0]      data_waddr;
    logic [DATA_W-1:0]      data_wdata;

    logic                   full;
    logic                   fresh;
    logic [IDX_W-1:0]       head_inc;
    logic                   live;

    // accept side
    assign name_dec = req.name_in - NAME_W'(1);
    assign rd_addr  = (req.cmd == CMD_CREATE) ? head_reg[ADDR_W-1:0]
                                              : name_dec[ADDR_W-1:0];
    assign rsp_free = !out_valid_reg || rsp.ready;

    fhla_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    fhla_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (data_rd)
    );

    // execute side
    assign full     = head_reg >= SLOTS_I;
    assign fresh    = head_reg >= fill_reg;
    assign head_inc = head_reg + IDX_W'(1);
    assign live     = inrange_reg && (IDX_W'(nidx_reg) < fill_reg)
                      && data_rd[OBJECT_BITS] && (data_rd[OBJECT_BITS-1:0] != '0);

    always_comb
    begin
        state_next      = state_reg;
        accept          = 1'b0;
        complete        = 1'b0;
        head_next       = head_reg;
        fill_next       = fill_reg;
        link_we         = 1'b0;
        link_waddr      = nidx_reg;
        link_wdata      = head_reg;
        data_we         = 1'b0;
        data_waddr      = nidx_reg;
        data_wdata      = {1'b0, data_rd[OBJECT_BITS-1:0]};
        out_name_next   = name_reg;
        out_live_next   = 1'b0;
        out_obj_next    = '0;
        out_status_next = ST_OK;
        req.ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    accept     = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    complete   = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (full)
                            begin
                                out_name_next   = '0;
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_name_next = NAME_W'(head_reg) + NAME_W'(1);
                                data_we       = 1'b1;
                                data_waddr    = head_reg[ADDR_W-1:0];
                                data_wdata    = {1'b1, obj_reg};
                                head_next     = fresh ? head_inc : link_rd;
                                fill_next     = fresh ? head_inc : fill_reg;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (live)
                            begin
                                out_live_next = 1'b1;
                                data_we       = 1'b1;
                                link_we       = 1'b1;
                                head_next     = IDX_W'(nidx_reg);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_LIVE;
                            end
                        end
                        default:
                        begin
                            if (live)
                            begin
                                out_live_next = 1'b1;
                                out_obj_next  = OBJ_W'(data_rd[OBJECT_BITS-1:0]);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_LIVE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.cmd;
            obj_reg     <= OBJECT_BITS'(req.object_value);
            name_reg    <= req.name_in;
            nidx_reg    <= name_dec[ADDR_W-1:0];
            inrange_reg <= (req.name_in != '0) && (req.name_in <= SLOTS_N);
        end
        if (complete)
        begin
            out_name_reg   <= out_name_next;
            out_live_reg   <= out_live_next;
            out_obj_reg    <= out_obj_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.name_out   = out_name_reg;
    assign rsp.is_live    = out_live_reg;
    assign rsp.object_out = out_obj_reg;
    assign rsp.status     = out_status_reg;

    // head is a freed slot, the first never-used slot, or the end mark when full
    `FHLA_ASSERT_SAME(a_head_within_fill, 1'b1, head_reg <= fill_reg,
        "free head beyond fill count")
    `FHLA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC,
        "accepted word did not enter execute")
    `FHLA_ASSERT_NEXT(a_create_issues_name,
        complete && (cmd_reg == CMD_CREATE) && !full,
        rsp.valid && (rsp.name_out != '0) && (rsp.status == ST_OK),
        "create with free slot did not issue a name")

endmodule

`default_nettype wire
